@@ hdl/bsv_pkg.sv @@
package bsv_pkg;

  // Parameter defaults
  localparam int MAX_NEST_DEF   = 32;
  localparam int FRAME_BITS_DEF = 16;

  // Port widths fixed by the field layout
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 104;
  localparam int OUT_TUSER_W = 4;
  localparam int DEPTH_W     = 6;
  localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd32;

  // Token events
  localparam logic [2:0] EV_NONE    = 3'd0;
  localparam logic [2:0] EV_INT     = 3'd1;
  localparam logic [2:0] EV_STR_HDR = 3'd2;
  localparam logic [2:0] EV_PAYLOAD = 3'd3;
  localparam logic [2:0] EV_LIST    = 3'd4;
  localparam logic [2:0] EV_DICT    = 3'd5;
  localparam logic [2:0] EV_CLOSE   = 3'd6;
  localparam logic [2:0] EV_TRAIL   = 3'd7;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BYTE     = 3'd1;
  localparam logic [2:0] ERR_OVERFLOW = 3'd2;
  localparam logic [2:0] ERR_DEPTH    = 3'd3;
  localparam logic [2:0] ERR_TRUNC    = 3'd4;

  // Byte classes found by the front end
  localparam logic [2:0] K_OTHER = 3'd0;
  localparam logic [2:0] K_INT   = 3'd1;
  localparam logic [2:0] K_LIST  = 3'd2;
  localparam logic [2:0] K_DICT  = 3'd3;
  localparam logic [2:0] K_END   = 3'd4;
  localparam logic [2:0] K_COLON = 3'd5;
  localparam logic [2:0] K_MINUS = 3'd6;

  // One classified input beat
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       is_digit;
    logic [3:0] digit;
    logic [2:0] kind;
  } beat_t;

  function automatic beat_t classify(input logic [7:0] b, input logic last);
    beat_t r;
    r.data     = b;
    r.last     = last;
    r.is_digit = (b >= 8'h30) && (b <= 8'h39);
    r.digit    = 4'(b - 8'h30);
    case (b)
      8'h69:   r.kind = K_INT;
      8'h6C:   r.kind = K_LIST;
      8'h64:   r.kind = K_DICT;
      8'h65:   r.kind = K_END;
      8'h3A:   r.kind = K_COLON;
      8'h2D:   r.kind = K_MINUS;
      default: r.kind = K_OTHER;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/bencode_stream_validator.sv @@
// Streaming bencode validator.
// Input: one frame byte per beat on in_tdata, in_tlast marking the frame's
// final byte. Output: exactly one beat per input byte, in order, giving the
// token event (out_tuser) plus value, payload byte, nesting level, done flag,
// sticky error code and consumed byte count (out_tdata).
// Throughput is one byte per cycle while out_tready stays high. An accepted
// byte is first written into the front queue, and the parser then carries it
// from the queue into the output register.
// The two-entry front queue decouples the input from the parser, so input
// beats keep flowing while a result waits in the output register; when the
// receiver holds out_tready low, the queue fills and in_tready drops.
// The user must write max_depth (cfg_wr_en/cfg_wr_data) only while the block
// is idle; the block does not enforce this. Reset (synchronous, rst_n low)
// empties the queue and output register, returns the parser to frame start
// and sets max_depth to 32; a frame's last byte also resets the parser.
module bencode_stream_validator
  import bsv_pkg::*;
#(
  parameter int MAX_NEST   = MAX_NEST_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [DEPTH_W-1:0]     cfg_wr_data,   // max_depth
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // [7:0] in_byte
  input  logic                   in_tlast,      // frame_last
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [63:0] value, [71:64] payload, [77:72] level, [78] done_res,
  // [81:79] error_code, [97:82] consumed_count, [103:98] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic [OUT_TUSER_W-1:0] out_tuser      // [2:0] event_res, [3] is_key
);

  logic  q_valid, q_pop;
  beat_t q_beat;

  bsv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_byte  (in_tdata),
    .in_last  (in_tlast),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_beat   (q_beat)
  );

  bsv_back #(
    .MAX_NEST   (MAX_NEST),
    .FRAME_BITS (FRAME_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_beat      (q_beat),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_data    (out_tdata),
    .out_user    (out_tuser)
  );

endmodule

@@ hdl/bsv_front.sv @@
module bsv_front
  import bsv_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        q_valid,
  input  logic        q_pop,
  output beat_t       q_beat
);

  beat_t      q_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_beat   = q_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_pop;

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // Classify each byte as it enters the queue.
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= classify(in_byte, in_last);
  end

endmodule

@@ hdl/bsv_back.sv @@
module bsv_back
  import bsv_pkg::*;
#(
  parameter int MAX_NEST   = MAX_NEST_DEF,
  parameter int FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [DEPTH_W-1:0]     cfg_wr_data,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  beat_t                  q_beat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [OUT_TDATA_W-1:0] out_data,
  output logic [OUT_TUSER_W-1:0] out_user
);

  localparam int LVL_W = $clog2(MAX_NEST + 2);

  // Parser phases
  localparam logic [2:0] PH_VALUE      = 3'd0;
  localparam logic [2:0] PH_INT_FIRST  = 3'd1;
  localparam logic [2:0] PH_INT_NEG    = 3'd2;
  localparam logic [2:0] PH_INT_DIGITS = 3'd3;
  localparam logic [2:0] PH_LEN_DIGITS = 3'd4;
  localparam logic [2:0] PH_PAYLOAD    = 3'd5;
  localparam logic [2:0] PH_DONE       = 3'd6;
  localparam logic [2:0] PH_ERROR      = 3'd7;

  // Container kinds
  localparam logic [1:0] C_NONE = 2'd0;
  localparam logic [1:0] C_LIST = 2'd1;
  localparam logic [1:0] C_DKEY = 2'd2;
  localparam logic [1:0] C_DVAL = 2'd3;

  localparam logic [67:0] POS_LIMIT = 68'h7FFFFFFFFFFFFFFF;
  localparam logic [67:0] NEG_LIMIT = 68'h8000000000000000;

  logic [DEPTH_W-1:0]    max_depth_r;
  logic [1:0]            stk_r   [MAX_NEST+1];
  logic [1:0]            stk_nxt [MAX_NEST+1];
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [2:0]            phase_r, phase_nxt;
  logic [63:0]           acc_r, acc_nxt;
  logic                  neg_r, neg_nxt;
  logic [62:0]           left_r, left_nxt;
  logic [FRAME_BITS-1:0] off_r, off_nxt;
  logic [2:0]            err_r, err_nxt;
  logic                  vdone_r, vdone_nxt;

  logic                  out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TUSER_W-1:0] out_user_r;

  logic                  take;
  logic [1:0]            top;
  logic [7:0]            eff;
  logic [67:0]           grown;
  logic                  push, pop, fin, done;
  logic [2:0]            ev, err;
  logic [63:0]           val;
  logic [7:0]            pl;
  logic                  key;
  logic [31:0]           off_ext;
  logic [15:0]           consumed;

  assign take      = q_valid && (!out_valid_r || out_ready);
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_user  = out_user_r;

  assign top   = (lvl_r != '0) ? stk_r[0] : C_NONE;
  assign eff   = (8'(max_depth_r) > 8'(MAX_NEST)) ? 8'(MAX_NEST) : 8'(max_depth_r);
  // acc*10 + digit, built from shifts
  assign grown = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + 68'(q_beat.digit);

  // Next-state logic for one beat.
  always_comb begin
    lvl_nxt   = lvl_r;
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    left_nxt  = left_r;
    off_nxt   = off_r;
    err_nxt   = err_r;
    vdone_nxt = vdone_r;
    push = 1'b0;
    pop  = 1'b0;
    fin  = 1'b0;
    done = 1'b0;
    ev   = EV_NONE;
    err  = ERR_NONE;
    val  = '0;
    pl   = '0;
    key  = 1'b0;

    if (phase_r == PH_DONE) begin
      ev = EV_TRAIL;
    end else if (phase_r != PH_ERROR) begin
      if (off_r != '1) off_nxt = off_r + 1'b1;
      case (phase_r)
        PH_VALUE: begin
          if (q_beat.kind == K_END && (top == C_LIST || top == C_DKEY)) begin
            pop = 1'b1;
            ev  = EV_CLOSE;
            fin = 1'b1;
          end else if (top == C_DKEY) begin
            if (q_beat.is_digit) begin
              acc_nxt   = 64'(q_beat.digit);
              phase_nxt = PH_LEN_DIGITS;
            end else begin
              err = ERR_BYTE;
            end
          end else if (8'(lvl_r) > eff) begin
            err = ERR_DEPTH;
          end else if (q_beat.kind == K_INT) begin
            acc_nxt   = '0;
            neg_nxt   = 1'b0;
            phase_nxt = PH_INT_FIRST;
          end else if (q_beat.is_digit) begin
            acc_nxt   = 64'(q_beat.digit);
            phase_nxt = PH_LEN_DIGITS;
          end else if (q_beat.kind == K_LIST || q_beat.kind == K_DICT) begin
            push = 1'b1;
            ev   = (q_beat.kind == K_LIST) ? EV_LIST : EV_DICT;
          end else begin
            err = ERR_BYTE;
          end
        end
        PH_INT_FIRST: begin
          if (q_beat.kind == K_MINUS) begin
            neg_nxt   = 1'b1;
            phase_nxt = PH_INT_NEG;
          end else if (q_beat.is_digit) begin
            acc_nxt   = 64'(q_beat.digit);
            phase_nxt = PH_INT_DIGITS;
          end else begin
            err = ERR_BYTE;
          end
        end
        PH_INT_NEG: begin
          if (q_beat.is_digit) begin
            acc_nxt   = 64'(q_beat.digit);
            phase_nxt = PH_INT_DIGITS;
          end else begin
            err = ERR_BYTE;
          end
        end
        PH_INT_DIGITS: begin
          if (q_beat.is_digit) begin
            if (grown > (neg_r ? NEG_LIMIT : POS_LIMIT)) err = ERR_OVERFLOW;
            else acc_nxt = grown[63:0];
          end else if (q_beat.kind == K_END) begin
            ev  = EV_INT;
            val = neg_r ? (64'd0 - acc_r) : acc_r;
            fin = 1'b1;
          end else begin
            err = ERR_BYTE;
          end
        end
        PH_LEN_DIGITS: begin
          if (q_beat.is_digit) begin
            if (grown > POS_LIMIT) err = ERR_OVERFLOW;
            else acc_nxt = grown[63:0];
          end else if (q_beat.kind == K_COLON) begin
            ev  = EV_STR_HDR;
            val = acc_r;
            key = (top == C_DKEY);
            if (acc_r == '0) begin
              fin = 1'b1;
            end else begin
              left_nxt  = acc_r[62:0];
              phase_nxt = PH_PAYLOAD;
            end
          end else begin
            err = ERR_BYTE;
          end
        end
        default: begin
          ev       = EV_PAYLOAD;
          pl       = q_beat.data;
          key      = (top == C_DKEY);
          left_nxt = left_r - 1'b1;
          if (left_r == 63'd1) fin = 1'b1;
        end
      endcase
    end

    // Stack shift: entry 0 is always the innermost container.
    for (int i = 0; i <= MAX_NEST; i++) stk_nxt[i] = stk_r[i];
    if (push) begin
      for (int i = MAX_NEST; i > 0; i--) stk_nxt[i] = stk_r[i-1];
      stk_nxt[0] = (q_beat.kind == K_LIST) ? C_LIST : C_DKEY;
      lvl_nxt    = lvl_r + 1'b1;
    end else if (pop) begin
      for (int i = 0; i < MAX_NEST; i++) stk_nxt[i] = stk_r[i+1];
      lvl_nxt = lvl_r - 1'b1;
    end

    // Value ended: the top value is complete, a parent dict flips or a list goes on.
    if (fin) begin
      if (lvl_nxt == '0) begin
        vdone_nxt = 1'b1;
        phase_nxt = PH_DONE;
        done      = 1'b1;
      end else begin
        if (stk_nxt[0] == C_DKEY) stk_nxt[0] = C_DVAL;
        else if (stk_nxt[0] == C_DVAL) stk_nxt[0] = C_DKEY;
        phase_nxt = PH_VALUE;
      end
    end

    if (err != ERR_NONE) begin
      err_nxt   = err;
      phase_nxt = PH_ERROR;
      ev   = EV_NONE;
      val  = '0;
      pl   = '0;
      key  = 1'b0;
      done = 1'b0;
    end
    if (q_beat.last && err_nxt == ERR_NONE && !vdone_nxt) err_nxt = ERR_TRUNC;

    off_ext  = 32'(off_nxt);
    consumed = !vdone_nxt ? 16'd0 : (off_ext > 32'hFFFF) ? 16'hFFFF : off_ext[15:0];
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) max_depth_r <= DEPTH_RESET;
    else if (cfg_wr_en) max_depth_r <= cfg_wr_data;
  end

  // Parser state; the last beat of a frame returns it to the frame-start values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r   <= '0;
      phase_r <= PH_VALUE;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      left_r  <= '0;
      off_r   <= '0;
      err_r   <= ERR_NONE;
      vdone_r <= 1'b0;
    end else if (take) begin
      if (q_beat.last) begin
        lvl_r   <= '0;
        phase_r <= PH_VALUE;
        acc_r   <= '0;
        neg_r   <= 1'b0;
        left_r  <= '0;
        off_r   <= '0;
        err_r   <= ERR_NONE;
        vdone_r <= 1'b0;
      end else begin
        lvl_r   <= lvl_nxt;
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        left_r  <= left_nxt;
        off_r   <= off_nxt;
        err_r   <= err_nxt;
        vdone_r <= vdone_nxt;
      end
    end
  end

  // Container stack entries carry no reset; only entries below the level are read.
  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i <= MAX_NEST; i++) stk_r[i] <= stk_nxt[i];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (take) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data_r <= {6'd0, consumed, err_nxt, done, DEPTH_W'(lvl_nxt), pl, val};
      out_user_r <= {key, ev};
    end
  end

endmodule

@@ hdl/bsv_checker.sv @@
module bsv_checker
  import bsv_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic [OUT_TUSER_W-1:0] out_tuser
);

  // No result beat is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A stalled result beat holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled output beat changed");

  // The top value can only complete with every container closed.
  a_done_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[78] |-> out_tdata[77:72] == '0)
    else $error("done reported inside an open container");

  // Trailing bytes follow a completed value, so the count is nonzero.
  a_trail_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2:0] == EV_TRAIL |-> out_tdata[97:82] != '0)
    else $error("trailing byte without consumed count");

endmodule

bind bencode_stream_validator bsv_checker u_bsv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
